[rtl/bcrf_pkg.sv]
// bcrf_pkg: types, constants and helpers shared by the climb rate filter
// used by bcrf_ctrl, bcrf_datapath and baro_climb_rate_filter
`default_nettype none
package bcrf_pkg;

  localparam int CLIMB_DEPTH  = 50;
  localparam int HEIGHT_DEPTH = 30;
  localparam int CSLOT_W      = 6;
  localparam int HSLOT_W      = 5;

  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [20:0] COEF_SQ    = 21'd1364787;
  localparam logic [22:0] COEF_LIN   = 23'd4795392;
  localparam logic signed [63:0] H_CONST = 64'sd13414 <<< 32;
  localparam logic [14:0] GLIDE_MAX  = 15'd25344;
  localparam logic [8:0]  KMH_SCALE  = 9'd360;
  localparam logic [5:0]  DIV_STEPS  = 6'd40;

  localparam logic [23:0] INV_REF_RST   = 24'd10726943;
  localparam logic [17:0] DAMPING_RST   = 18'd117965;
  localparam logic [19:0] INV_T2_RST    = 20'd65536;
  localparam logic [15:0] PERIOD_RST    = 16'd6554;
  localparam logic [15:0] WEIGHT_RST    = 16'd655;
  localparam logic [7:0]  HIST_RST      = 8'd5;

  typedef enum logic [2:0] {
    CFG_INV_REF   = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_INV_T2    = 3'd2,
    CFG_PERIOD    = 3'd3,
    CFG_WEIGHT    = 3'd4,
    CFG_HIST      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] pressure_pa;
    logic [15:0] ground_speed;
  } in_t;

  typedef struct packed {
    logic signed [23:0] altitude;
    logic signed [23:0] climb_rate;
    logic signed [23:0] climb_average;
    logic [14:0]        glide_ratio;
    logic               history_strobe;
    logic [5:0]         climb_slot;
    logic [4:0]         height_slot;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_X, ST_X2, ST_HSQ, ST_HLIN, ST_HSAT, ST_UT,
    ST_PRE1, ST_PRE_DT, ST_PRE2, ST_SHIFT, ST_DT, ST_DIFF, ST_Y,
    ST_YI1, ST_YI2, ST_AVG1, ST_AVG2, ST_DEN, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_X, OP_X2, OP_HSQ, OP_HLIN, OP_HSAT, OP_UT,
    OP_PRE1, OP_DT, OP_PRE2, OP_SHIFT, OP_DIFF, OP_Y, OP_YI1, OP_YI2,
    OP_AVG1, OP_AVG2, OP_DEN, OP_DIV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic first_sample;
    logic y_neg;
    logic out_valid;
  } status_t;

  function automatic logic signed [23:0] sat24(input logic signed [53:0] v);
    logic signed [23:0] r;
    if (v > 54'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -54'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/bcrf_ctrl.sv]
// bcrf_ctrl: sequencer for the climb rate filter, one datapath step per state
// depends on bcrf_pkg
`default_nettype none
module bcrf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             out_stall,
  input  wire bcrf_pkg::status_t status,
  output bcrf_pkg::cmd_t        cmd,
  output logic                  busy
);

  bcrf_pkg::state_t state, state_next;
  logic [5:0] div_cnt, div_cnt_next;
  logic       can_emit;

  assign can_emit = !status.out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bcrf_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    case (state)
      bcrf_pkg::ST_IDLE:   if (in_valid) state_next = bcrf_pkg::ST_X;
      bcrf_pkg::ST_X:      state_next = bcrf_pkg::ST_X2;
      bcrf_pkg::ST_X2:     state_next = bcrf_pkg::ST_HSQ;
      bcrf_pkg::ST_HSQ:    state_next = bcrf_pkg::ST_HLIN;
      bcrf_pkg::ST_HLIN:   state_next = bcrf_pkg::ST_HSAT;
      bcrf_pkg::ST_HSAT:   state_next = bcrf_pkg::ST_UT;
      bcrf_pkg::ST_UT: begin
        state_next = status.first_sample ? bcrf_pkg::ST_PRE1 : bcrf_pkg::ST_SHIFT;
      end
      bcrf_pkg::ST_PRE1:   state_next = bcrf_pkg::ST_PRE_DT;
      bcrf_pkg::ST_PRE_DT: state_next = bcrf_pkg::ST_PRE2;
      bcrf_pkg::ST_PRE2:   state_next = bcrf_pkg::ST_SHIFT;
      bcrf_pkg::ST_SHIFT:  state_next = bcrf_pkg::ST_DT;
      bcrf_pkg::ST_DT:     state_next = bcrf_pkg::ST_DIFF;
      bcrf_pkg::ST_DIFF:   state_next = bcrf_pkg::ST_Y;
      bcrf_pkg::ST_Y:      state_next = bcrf_pkg::ST_YI1;
      bcrf_pkg::ST_YI1:    state_next = bcrf_pkg::ST_YI2;
      bcrf_pkg::ST_YI2:    state_next = bcrf_pkg::ST_AVG1;
      bcrf_pkg::ST_AVG1:   state_next = bcrf_pkg::ST_AVG2;
      bcrf_pkg::ST_AVG2:   state_next = bcrf_pkg::ST_DEN;
      bcrf_pkg::ST_DEN: begin
        div_cnt_next = '0;
        state_next   = status.y_neg ? bcrf_pkg::ST_DIV : bcrf_pkg::ST_DONE;
      end
      bcrf_pkg::ST_DIV: begin
        div_cnt_next = div_cnt + 6'd1;
        if (div_cnt == bcrf_pkg::DIV_STEPS - 6'd1) state_next = bcrf_pkg::ST_DONE;
      end
      bcrf_pkg::ST_DONE:   if (can_emit) state_next = bcrf_pkg::ST_IDLE;
      default:             state_next = bcrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = bcrf_pkg::OP_NONE;
    busy   = 1'b1;
    case (state)
      bcrf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_valid) cmd.op = bcrf_pkg::OP_LOAD;
      end
      bcrf_pkg::ST_X:      cmd.op = bcrf_pkg::OP_X;
      bcrf_pkg::ST_X2:     cmd.op = bcrf_pkg::OP_X2;
      bcrf_pkg::ST_HSQ:    cmd.op = bcrf_pkg::OP_HSQ;
      bcrf_pkg::ST_HLIN:   cmd.op = bcrf_pkg::OP_HLIN;
      bcrf_pkg::ST_HSAT:   cmd.op = bcrf_pkg::OP_HSAT;
      bcrf_pkg::ST_UT:     cmd.op = bcrf_pkg::OP_UT;
      bcrf_pkg::ST_PRE1:   cmd.op = bcrf_pkg::OP_PRE1;
      bcrf_pkg::ST_PRE_DT: cmd.op = bcrf_pkg::OP_DT;
      bcrf_pkg::ST_PRE2:   cmd.op = bcrf_pkg::OP_PRE2;
      bcrf_pkg::ST_SHIFT:  cmd.op = bcrf_pkg::OP_SHIFT;
      bcrf_pkg::ST_DT:     cmd.op = bcrf_pkg::OP_DT;
      bcrf_pkg::ST_DIFF:   cmd.op = bcrf_pkg::OP_DIFF;
      bcrf_pkg::ST_Y:      cmd.op = bcrf_pkg::OP_Y;
      bcrf_pkg::ST_YI1:    cmd.op = bcrf_pkg::OP_YI1;
      bcrf_pkg::ST_YI2:    cmd.op = bcrf_pkg::OP_YI2;
      bcrf_pkg::ST_AVG1:   cmd.op = bcrf_pkg::OP_AVG1;
      bcrf_pkg::ST_AVG2:   cmd.op = bcrf_pkg::OP_AVG2;
      bcrf_pkg::ST_DEN:    cmd.op = bcrf_pkg::OP_DEN;
      bcrf_pkg::ST_DIV:    cmd.op = bcrf_pkg::OP_DIV;
      bcrf_pkg::ST_DONE:   if (can_emit) cmd.op = bcrf_pkg::OP_EMIT;
      default:             cmd.op = bcrf_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/bcrf_datapath.sv]
// bcrf_datapath: registers, shared multiplier, serial divider and output beat
// depends on bcrf_pkg
`default_nettype none
module bcrf_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bcrf_pkg::cmd_t  cmd,
  input  wire bcrf_pkg::in_t   in_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [23:0]     cfg_data,
  input  wire logic            out_stall,
  output bcrf_pkg::status_t    status,
  output logic                 out_valid,
  output bcrf_pkg::out_t       out_data
);

  // configuration
  logic [23:0] inv_ref;
  logic [17:0] damping;
  logic [19:0] inv_t2;
  logic [15:0] period;
  logic [15:0] weight;
  logic [7:0]  hist_period;

  // filter state
  logic signed [39:0] yi1, ui1, yi2;
  logic               first_sample;
  logic signed [23:0] avg;
  logic [7:0]         tick;
  logic [bcrf_pkg::CSLOT_W-1:0] cptr;
  logic [bcrf_pkg::HSLOT_W-1:0] hptr;

  // working registers
  logic [16:0]        pres;
  logic [15:0]        speed;
  logic [24:0]        xr;
  logic [25:0]        x2;
  logic signed [63:0] acc;
  logic signed [23:0] h;
  logic signed [39:0] ut;
  logic signed [41:0] dtt;
  logic signed [43:0] ypre;
  logic signed [23:0] y;
  logic [31:0]        den;
  logic [31:0]        rem;
  logic [39:0]        quo;

  logic signed [bcrf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bcrf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bcrf_pkg::PROD_W-1:0]  prod;
  logic [16:0]        wcomp;
  logic [32:0]        trial;
  logic signed [43:0] pre2_sum;
  logic signed [63:0] avg_sum;
  logic               strobe;
  logic [14:0]        glide;

  assign wcomp = 17'h10000 - {1'b0, weight};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bcrf_pkg::OP_X: begin
        mul_a = signed'({27'd0, pres});
        mul_b = signed'({2'd0, inv_ref});
      end
      bcrf_pkg::OP_X2: begin
        mul_a = signed'({19'd0, xr});
        mul_b = signed'({1'b0, xr});
      end
      bcrf_pkg::OP_HSQ: begin
        mul_a = signed'({18'd0, x2});
        mul_b = signed'({5'd0, bcrf_pkg::COEF_SQ});
      end
      bcrf_pkg::OP_HLIN: begin
        mul_a = signed'({19'd0, xr});
        mul_b = signed'({3'd0, bcrf_pkg::COEF_LIN});
      end
      bcrf_pkg::OP_UT: begin
        mul_a = 44'(h);
        mul_b = signed'({10'd0, period});
      end
      bcrf_pkg::OP_DT: begin
        mul_a = 44'(yi1);
        mul_b = signed'({8'd0, damping});
      end
      bcrf_pkg::OP_Y: begin
        mul_a = ypre;
        mul_b = signed'({6'd0, inv_t2});
      end
      bcrf_pkg::OP_YI1: begin
        mul_a = 44'(y);
        mul_b = signed'({10'd0, period});
      end
      bcrf_pkg::OP_YI2: begin
        mul_a = 44'(yi1);
        mul_b = signed'({10'd0, period});
      end
      bcrf_pkg::OP_AVG1: begin
        mul_a = 44'(avg);
        mul_b = signed'({9'd0, wcomp});
      end
      bcrf_pkg::OP_AVG2: begin
        mul_a = 44'(y);
        mul_b = signed'({10'd0, weight});
      end
      bcrf_pkg::OP_DEN: begin
        mul_a = -(44'(y));
        mul_b = signed'({17'd0, bcrf_pkg::KMH_SCALE});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign trial    = {rem, quo[39]};
  assign pre2_sum = (44'(ui1) <<< 1) - 44'(dtt);
  assign avg_sum  = acc + prod[63:0];
  assign strobe   = tick >= hist_period;
  assign glide    = (quo > 40'(bcrf_pkg::GLIDE_MAX)) ? bcrf_pkg::GLIDE_MAX : quo[14:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_ref     <= bcrf_pkg::INV_REF_RST;
      damping     <= bcrf_pkg::DAMPING_RST;
      inv_t2      <= bcrf_pkg::INV_T2_RST;
      period      <= bcrf_pkg::PERIOD_RST;
      weight      <= bcrf_pkg::WEIGHT_RST;
      hist_period <= bcrf_pkg::HIST_RST;
    end else if (cfg_we) begin
      case (bcrf_pkg::cfg_idx_t'(cfg_index))
        bcrf_pkg::CFG_INV_REF: inv_ref     <= cfg_data;
        bcrf_pkg::CFG_DAMPING: damping     <= cfg_data[17:0];
        bcrf_pkg::CFG_INV_T2:  inv_t2      <= cfg_data[19:0];
        bcrf_pkg::CFG_PERIOD:  period      <= cfg_data[15:0];
        bcrf_pkg::CFG_WEIGHT:  weight      <= cfg_data[15:0];
        bcrf_pkg::CFG_HIST:    hist_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // filter state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      yi1          <= '0;
      ui1          <= '0;
      yi2          <= '0;
      first_sample <= 1'b1;
      avg          <= '0;
      tick         <= '0;
      cptr         <= '0;
      hptr         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.op == bcrf_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        bcrf_pkg::OP_PRE1: begin
          yi1 <= 40'(signed'({h, 8'd0}));
          ui1 <= ut;
        end
        bcrf_pkg::OP_PRE2: begin
          yi2          <= pre2_sum[39:0];
          first_sample <= 1'b0;
        end
        bcrf_pkg::OP_SHIFT: begin
          ui1 <= ut;
          yi2 <= yi2 - ui1;
        end
        bcrf_pkg::OP_YI1: yi1 <= yi1 + prod[55:16];
        bcrf_pkg::OP_YI2: yi2 <= yi2 + prod[55:16];
        bcrf_pkg::OP_AVG2: avg <= avg_sum[39:16];
        bcrf_pkg::OP_EMIT: begin
          tick      <= (strobe ? 8'd0 : tick) + 8'd1;
          if (strobe) begin
            cptr <= (cptr == bcrf_pkg::CSLOT_W'(bcrf_pkg::CLIMB_DEPTH - 1))
                    ? '0 : cptr + 1'b1;
            hptr <= (hptr == bcrf_pkg::HSLOT_W'(bcrf_pkg::HEIGHT_DEPTH - 1))
                    ? '0 : hptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      bcrf_pkg::OP_LOAD: begin
        pres  <= in_data.pressure_pa;
        speed <= in_data.ground_speed;
      end
      bcrf_pkg::OP_X:    xr   <= prod[40:16];
      bcrf_pkg::OP_X2:   x2   <= prod[49:24];
      bcrf_pkg::OP_HSQ:  acc  <= prod[63:0] + bcrf_pkg::H_CONST;
      bcrf_pkg::OP_HLIN: acc  <= acc - prod[63:0];
      bcrf_pkg::OP_HSAT: h    <= bcrf_pkg::sat24(54'(signed'(acc[63:24])));
      bcrf_pkg::OP_UT:   ut   <= prod[47:8];
      bcrf_pkg::OP_DT:   dtt  <= prod[57:16];
      bcrf_pkg::OP_DIFF: ypre <= 44'(ui1) - 44'(dtt) - 44'(yi2);
      bcrf_pkg::OP_Y:    y    <= bcrf_pkg::sat24(prod[69:16]);
      bcrf_pkg::OP_AVG1: acc  <= prod[63:0];
      bcrf_pkg::OP_DEN: begin
        den <= prod[31:0];
        rem <= '0;
        quo <= {speed, 24'd0};
      end
      bcrf_pkg::OP_DIV: begin
        // restoring division, one quotient bit a cycle
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
          quo <= {quo[38:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[38:0], 1'b0};
        end
      end
      bcrf_pkg::OP_EMIT: begin
        out_data.altitude       <= h;
        out_data.climb_rate     <= y;
        out_data.climb_average  <= avg;
        out_data.glide_ratio    <= y[23] ? glide : bcrf_pkg::GLIDE_MAX;
        out_data.history_strobe <= strobe;
        out_data.climb_slot     <= strobe ? cptr : '0;
        out_data.height_slot    <= strobe ? hptr : '0;
      end
      default: ;
    endcase
  end

  assign status.first_sample = first_sample;
  assign status.y_neg        = y[23];
  assign status.out_valid    = out_valid;

  a_glide_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.glide_ratio <= bcrf_pkg::GLIDE_MAX)
    else $error("glide ratio above limit");

  a_slots_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.history_strobe) |->
      (out_data.climb_slot == '0 && out_data.height_slot == '0))
    else $error("ring slot without strobe");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    cptr < bcrf_pkg::CSLOT_W'(bcrf_pkg::CLIMB_DEPTH) &&
    hptr < bcrf_pkg::HSLOT_W'(bcrf_pkg::HEIGHT_DEPTH))
    else $error("ring pointer out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bcrf_pkg::OP_EMIT) |-> (!out_valid || !out_stall))
    else $error("output overwritten while stalled");

endmodule
`default_nettype wire

[rtl/baro_climb_rate_filter.sv]
// baro_climb_rate_filter: top level, pressure to altitude, climb rate and glide
// depends on bcrf_pkg, bcrf_ctrl, bcrf_datapath
//
// Input channel: one beat per barometer tick (pressure, ground speed), taken
// when in_valid is high and in_stall is low. Output channel: one beat per input
// beat (altitude, climb rate, climb average, glide ratio, history strobe and
// ring slots), taken when out_valid is high and out_stall is low.
// Configuration: six registers written through cfg_valid/cfg_ready,
// cfg_ready is always high; write only while no beat is in flight.
// The first sample adds preset steps before the filter update, and a sinking
// sample adds the serial glide-ratio divider before the output beat.
// One beat is worked at a time on a single shared multiplier, so the
// input is taken again in the cycle after the previous beat has reached
// the output register. A stalled output beat holds; the next result waits
// in the datapath until the output register is free.
// Reset (synchronous, rst high) restores register defaults, clears the
// filter integrators and arms the first-sample preset.
`default_nettype none
module baro_climb_rate_filter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bcrf_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bcrf_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [23:0]    cfg_data
);

  bcrf_pkg::cmd_t    cmd;
  bcrf_pkg::status_t status;
  logic              busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  bcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  bcrf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking regression for baro_climb_rate_filter
// depends on bcrf_pkg and the rtl of baro_climb_rate_filter; predicts each beat itself
`timescale 1ns / 100ps
module testbench;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  bcrf_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  bcrf_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  baro_climb_rate_filter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model copy of registers and filter state
  logic [23:0] m_inv_ref;
  logic [17:0] m_damping;
  logic [19:0] m_inv_t2;
  logic [15:0] m_period;
  logic [15:0] m_weight;
  logic [7:0]  m_hist;
  longint yi_in, yi_one, yi_two, avg_acc;
  logic first_flag;
  logic [7:0] tick_cnt;
  int cptr, hptr;

  bcrf_pkg::out_t expected_beats[$];
  int fail_count;
  int stall_pct;
  int gap_max;
  bit hold_req;
  int walk_p;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("baro_climb_rate_filter regression: fail");
    $finish;
  end

  function automatic longint wrap40(longint v);
    logic signed [39:0] t;
    t = v[39:0];
    return longint'(t);
  endfunction

  function automatic longint sat24v(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic bcrf_pkg::out_t predict_filter(bcrf_pkg::in_t d);
    bcrf_pkg::out_t r;
    longint unsigned x, x2, den, q;
    longint hq, h, u, ut, sub, y, ts, dt, glide;
    ts = longint'(m_period);
    dt = longint'(m_damping);
    x = (longint'(d.pressure_pa) * longint'(m_inv_ref)) >> 16;
    x2 = (x * x) >> 24;
    hq = 64'sd1364787 * longint'(x2) + (64'sd13414 <<< 32) - 64'sd4795392 * longint'(x);
    h = sat24v(hq >>> 24);
    u = h * 256;
    ut = (h * ts) >>> 8;
    if (first_flag) begin
      yi_one = wrap40(u);
      yi_in = wrap40(ut);
      yi_two = wrap40(2 * yi_in - ((dt * yi_one) >>> 16));
      first_flag = 1'b0;
    end
    sub = yi_in;
    yi_in = wrap40(ut);
    yi_two = wrap40(yi_two - sub);
    y = yi_in - ((dt * yi_one) >>> 16) - yi_two;
    y = sat24v((y * longint'(m_inv_t2)) >>> 16);
    yi_one = wrap40(yi_one + ((y * ts) >>> 16));
    yi_two = wrap40(yi_two + ((yi_one * ts) >>> 16));
    if (y < 0) begin
      den = 360 * longint'(-y);
      q = (longint'(d.ground_speed) << 24) / den;
      glide = (q > 25344) ? 25344 : longint'(q);
    end else begin
      glide = 25344;
    end
    avg_acc = ((65536 - longint'(m_weight)) * avg_acc + longint'(m_weight) * y) >>> 16;
    r = '0;
    if (tick_cnt >= m_hist) begin
      r.history_strobe = 1'b1;
      r.climb_slot = cptr[5:0];
      r.height_slot = hptr[4:0];
      cptr = (cptr + 1) % bcrf_pkg::CLIMB_DEPTH;
      hptr = (hptr + 1) % bcrf_pkg::HEIGHT_DEPTH;
      tick_cnt = 8'd0;
    end
    tick_cnt = tick_cnt + 8'd1;
    r.altitude = h[23:0];
    r.climb_rate = y[23:0];
    r.climb_average = avg_acc[23:0];
    r.glide_ratio = glide[14:0];
    return r;
  endfunction

  // one input beat, with the model run at hand-off; random gap ahead of it
  task automatic send_sample(logic [16:0] p, logic [15:0] s);
    bcrf_pkg::in_t d;
    if (gap_max > 0 && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
    end
    d.pressure_pa = p;
    d.ground_speed = s;
    in_valid <= 1'b1;
    in_data <= d;
    expected_beats.push_back(predict_filter(d));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(bcrf_pkg::cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bcrf_pkg::CFG_INV_REF: m_inv_ref = val;
      bcrf_pkg::CFG_DAMPING: m_damping = val[17:0];
      bcrf_pkg::CFG_INV_T2:  m_inv_t2 = val[19:0];
      bcrf_pkg::CFG_PERIOD:  m_period = val[15:0];
      bcrf_pkg::CFG_WEIGHT:  m_weight = val[15:0];
      bcrf_pkg::CFG_HIST:    m_hist = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // mostly a slow pressure walk so the filter settles and sinks, some noise
  task automatic send_flight(int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        send_sample(17'($urandom_range(131071)), 16'($urandom_range(65535)));
      end else begin
        walk_p = walk_p + $urandom_range(80) - 40;
        if (walk_p < 60000) walk_p = 60000;
        if (walk_p > 110000) walk_p = 110000;
        send_sample(walk_p[16:0], 16'($urandom_range(65535)));
      end
    end
  endtask

  task automatic test_directed();
    gap_max = 0;
    stall_pct = 0;
    send_sample(17'd101325, 16'd0);
    send_sample(17'd0, 16'd65535);
    send_sample(17'd131071, 16'd65535);
    send_sample(17'd131071, 16'd0);
    send_sample(17'd0, 16'd0);
    for (int i = 0; i < 12; i++) begin
      // rising pressure means sinking
      send_sample(17'd95000 + 17'(i * 300), 16'(5000 * i));
    end
    for (int i = 0; i < 6; i++) send_sample(17'd99000 - 17'(i * 400), 16'hAAAA);
    send_sample(17'h15555, 16'h5555);
    drain_results();
  endtask

  task automatic test_extreme_registers();
    write_reg(bcrf_pkg::CFG_INV_REF, 24'd16777215);
    write_reg(bcrf_pkg::CFG_DAMPING, 24'd262143);
    write_reg(bcrf_pkg::CFG_INV_T2, 24'd1048575);
    write_reg(bcrf_pkg::CFG_PERIOD, 24'd65535);
    write_reg(bcrf_pkg::CFG_WEIGHT, 24'd65535);
    write_reg(bcrf_pkg::CFG_HIST, 24'd1);
    gap_max = 4;
    stall_pct = 30;
    send_flight(60);
    drain_results();
    write_reg(bcrf_pkg::CFG_INV_REF, 24'd1);
    write_reg(bcrf_pkg::CFG_DAMPING, 24'd0);
    write_reg(bcrf_pkg::CFG_INV_T2, 24'd1);
    write_reg(bcrf_pkg::CFG_PERIOD, 24'd1);
    write_reg(bcrf_pkg::CFG_WEIGHT, 24'd1);
    write_reg(bcrf_pkg::CFG_HIST, 24'd255);
    send_flight(40);
    drain_results();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(bcrf_pkg::CFG_INV_REF, 24'($urandom_range(16777215, 8000000)));
      write_reg(bcrf_pkg::CFG_DAMPING, 24'($urandom_range(262143)));
      write_reg(bcrf_pkg::CFG_INV_T2, 24'($urandom_range(1048575, 1)));
      write_reg(bcrf_pkg::CFG_PERIOD, 24'($urandom_range(65535, 1)));
      write_reg(bcrf_pkg::CFG_WEIGHT, 24'($urandom_range(65535, 1)));
      write_reg(bcrf_pkg::CFG_HIST, 24'($urandom_range(8, 1)));
      gap_max = (ph % 2) ? 0 : 10;
      stall_pct = ph * 15;
      send_flight(50);
      drain_results();
    end
  endtask

  task automatic test_defaults_and_backpressure();
    write_reg(bcrf_pkg::CFG_INV_REF, bcrf_pkg::INV_REF_RST);
    write_reg(bcrf_pkg::CFG_DAMPING, 24'(bcrf_pkg::DAMPING_RST));
    write_reg(bcrf_pkg::CFG_INV_T2, 24'(bcrf_pkg::INV_T2_RST));
    write_reg(bcrf_pkg::CFG_PERIOD, 24'(bcrf_pkg::PERIOD_RST));
    write_reg(bcrf_pkg::CFG_WEIGHT, 24'(bcrf_pkg::WEIGHT_RST));
    write_reg(bcrf_pkg::CFG_HIST, 24'(bcrf_pkg::HIST_RST));
    gap_max = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    send_flight(20);
    gap_max = 6;
    stall_pct = 40;
    send_flight(80);
    drain_results();
  endtask

  // receiver: random stall pattern, with one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing expected");
        fail_count++;
      end else begin
        bcrf_pkg::out_t e;
        e = expected_beats.pop_front();
        check_field("altitude", e.altitude, out_data.altitude);
        check_field("climb_rate", e.climb_rate, out_data.climb_rate);
        check_field("climb_average", e.climb_average, out_data.climb_average);
        check_field("glide_ratio", e.glide_ratio, out_data.glide_ratio);
        check_field("history_strobe", e.history_strobe, out_data.history_strobe);
        check_field("climb_slot", e.climb_slot, out_data.climb_slot);
        check_field("height_slot", e.height_slot, out_data.height_slot);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    stall_pct = 0;
    gap_max = 0;
    hold_req = 1'b0;
    walk_p = 98000;
    m_inv_ref = bcrf_pkg::INV_REF_RST;
    m_damping = bcrf_pkg::DAMPING_RST;
    m_inv_t2 = bcrf_pkg::INV_T2_RST;
    m_period = bcrf_pkg::PERIOD_RST;
    m_weight = bcrf_pkg::WEIGHT_RST;
    m_hist = bcrf_pkg::HIST_RST;
    yi_in = 0;
    yi_one = 0;
    yi_two = 0;
    avg_acc = 0;
    first_flag = 1'b1;
    tick_cnt = 8'd0;
    cptr = 0;
    hptr = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_registers();
    test_random_settings();
    test_defaults_and_backpressure();
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("baro_climb_rate_filter regression: pass");
    end else begin
      $display("baro_climb_rate_filter regression: fail");
    end
    $finish;
  end

endmodule

[baro_climb_rate_filter.f]
rtl/bcrf_pkg.sv
rtl/bcrf_ctrl.sv
rtl/bcrf_datapath.sv
rtl/baro_climb_rate_filter.sv
tb/testbench.sv
